[rtl/rna_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rna_pkg: shared constants and codes of the rational number ALU
// Operation and status codes, default operand width, field and result widths.
// ----------------------------------------------------------------------------
package rna_pkg;
  localparam int OperandWidthDefault = 32;
  localparam int FieldWidth = 32;
  localparam int ResWidth = 64;

  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_SIMP = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DEN_ZERO = 2'd1;
  localparam logic [1:0] ST_ZERO_ZERO = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;
endpackage

[rtl/rational_number_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_number_alu: sequential rational arithmetic with gcd simplify
// Add, subtract, multiply, divide of two fractions, and simplify of A.
// ----------------------------------------------------------------------------
// One item is in work at a time. Add and subtract make three passes through
// the shared OPERAND_WIDTH-bit multiplier, then go through the sum state and
// the output state; multiply and divide make two passes; unused action codes
// go straight to the output state. Simplify loads the magnitudes, runs a
// binary gcd with one shift or subtract step per cycle until one value is
// zero, and then two restoring divisions, one quotient bit per cycle.
// The result waits in an output register until taken; the next beat can be
// accepted in the cycle after that.
module rational_number_alu #(
  parameter int OPERAND_WIDTH = rna_pkg::OperandWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zeros
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // res_num[63:0], res_den[127:64], status[129:128], zeros
  output logic [135:0] m_tdata
);
  import rna_pkg::*;

  localparam int W = OPERAND_WIDTH;
  localparam int CW = $clog2(2 * W + 2);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_GCD  = 9'b000100000,
    S_DIVN = 9'b001000000,
    S_DIVD = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  logic [2:0] act;
  logic signed [W-1:0] an, ad, bn, bd;
  logic signed [ResWidth-1:0] p, q, rd;
  logic [W-1:0] gx, gy;
  logic [CW-1:0] shift;
  logic [CW-1:0] cnt;
  logic [W-1:0] gcd_val;
  logic [W-1:0] quo, dvd;
  logic [W:0] rem;
  logic [ResWidth-1:0] out_num, out_den;
  logic [1:0] out_st;

  // Shared multiplier operands.
  logic signed [W-1:0] mul_a, mul_b;
  logic signed [2*W-1:0] mul_p;
  logic signed [ResWidth-1:0] mul_x;

  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (state)
      S_MUL0: begin
        mul_a = (act == ACT_MUL) ? an : an;
        mul_b = (act == ACT_MUL) ? bn : bd;
      end
      S_MUL1: begin
        mul_a = ad;
        mul_b = (act == ACT_MUL || act == ACT_ADD || act == ACT_SUB) ? bd : bn;
      end
      S_MUL2: begin
        mul_a = ad;
        mul_b = bn;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;
  assign mul_x = ResWidth'(mul_p);

  logic [W-1:0] mag_an, mag_ad;
  assign mag_an = an[W-1] ? W'(-an) : W'(an);
  assign mag_ad = ad[W-1] ? W'(-ad) : W'(ad);

  // Sum or difference and overflow check.
  logic [ResWidth-1:0] sum;
  logic ovf;
  always_comb begin
    if (act == ACT_ADD) begin
      sum = p + q;
      ovf = (p[ResWidth-1] == q[ResWidth-1]) && (sum[ResWidth-1] != p[ResWidth-1]);
    end else begin
      sum = p - q;
      ovf = (p[ResWidth-1] != q[ResWidth-1]) && (sum[ResWidth-1] != p[ResWidth-1]);
    end
  end

  // Binary gcd step: gx and gy kept odd-aligned after common twos removed.
  logic [W-1:0] gdiff;
  assign gdiff = (gx > gy) ? gx - gy : gy - gx;

  // Restoring division step.
  logic [W:0] rem_sh, rem_sub;
  assign rem_sh = {rem[W-1:0], dvd[W-1]};
  assign rem_sub = rem_sh - {1'b0, gcd_val};

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act <= s_tdata[2:0];
            an <= W'(s_tdata[3 +: FieldWidth]);
            ad <= W'(s_tdata[35 +: FieldWidth]);
            bn <= W'(s_tdata[67 +: FieldWidth]);
            bd <= W'(s_tdata[99 +: FieldWidth]);
            if (s_tdata[2:0] == ACT_SIMP) state <= S_GCD;
            else if (s_tdata[2:0] > ACT_SIMP) begin
              out_num <= '0;
              out_den <= '0;
              out_st <= ST_DEN_ZERO;
              state <= S_OUT;
              m_tvalid <= 1'b1;
            end else state <= S_MUL0;
            shift <= '0;
            gx <= '0;
            gy <= '0;
            cnt <= '0;
          end
        end
        S_MUL0: begin
          p <= mul_x;
          state <= S_MUL1;
        end
        S_MUL1: begin
          rd <= mul_x;
          state <= (act == ACT_MUL || act == ACT_DIV) ? S_SUM : S_MUL2;
        end
        S_MUL2: begin
          q <= mul_x;
          state <= S_SUM;
        end
        S_SUM: begin
          if (act == ACT_MUL || act == ACT_DIV) begin
            out_num <= p;
            out_den <= rd;
            out_st <= (rd == '0) ? ST_DEN_ZERO : ST_OK;
          end else begin
            out_num <= sum;
            out_den <= rd;
            out_st <= ovf ? ST_OVERFLOW : ((rd == '0) ? ST_DEN_ZERO : ST_OK);
          end
          m_tvalid <= 1'b1;
          state <= S_OUT;
        end
        S_GCD: begin
          // cnt 0 loads magnitudes; afterwards one step per cycle.
          if (cnt == '0) begin
            gx <= mag_an;
            gy <= mag_ad;
            cnt <= CW'(1);
          end else if (gx == '0 || gy == '0) begin
            gcd_val <= (gx | gy) << shift;
            if ((gx | gy) == '0) begin
              out_num <= '0;
              out_den <= '0;
              out_st <= ST_ZERO_ZERO;
              m_tvalid <= 1'b1;
              state <= S_OUT;
            end else begin
              dvd <= mag_an;
              rem <= '0;
              cnt <= '0;
              state <= S_DIVN;
            end
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            shift <= shift + CW'(1);
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx >= gy) begin
            gx <= gdiff;
          end else begin
            gy <= gdiff;
          end
        end
        S_DIVN, S_DIVD: begin
          quo <= {quo[W-2:0], ~rem_sub[W]};
          if (cnt == CW'(W - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (state == S_DIVN) begin
              out_num <= an[W-1]
                ? ResWidth'(-$signed({1'b0, quo[W-2:0], ~rem_sub[W]}))
                : ResWidth'({quo[W-2:0], ~rem_sub[W]});
              dvd <= mag_ad;
              state <= S_DIVD;
            end else begin
              out_den <= ad[W-1]
                ? ResWidth'(-$signed({1'b0, quo[W-2:0], ~rem_sub[W]}))
                : ResWidth'({quo[W-2:0], ~rem_sub[W]});
              out_st <= ({quo[W-2:0], ~rem_sub[W]} == '0) ? ST_DEN_ZERO : ST_OK;
              m_tvalid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt + CW'(1);
            if (!rem_sub[W]) rem <= rem_sub;
            else rem <= rem_sh;
            dvd <= {dvd[W-2:0], 1'b0};
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_st, out_den, out_num};

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == S_OUT) else $error("result valid outside output state");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accepting while result held");
  a_release: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |=> !m_tvalid) else $error("result repeated");
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rational_number_alu
// A directed table of edge cases, then random fractions under random gaps and
// back-pressure. Every result beat is compared against the table or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;
  import rna_pkg::*;

  localparam int OW = OperandWidthDefault;
  localparam int CycleLimit = 6000000;

  typedef struct packed {
    logic [63:0] num;
    logic [63:0] den;
    logic [1:0]  status;
  } frac_res_t;

  typedef struct {
    logic [2:0]  action;
    logic [31:0] an, ad, bn, bd;
    bit          typed;
    frac_res_t   res;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [135:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [135:0] m_tdata;

  frac_res_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off_req = 0;
  bit stim_done = 0;

  rational_number_alu dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [63:0] sext_op(logic [31:0] x);
    logic [63:0] v;
    v = {32'd0, x} & ((64'd1 << OW) - 64'd1);
    if (v[OW-1]) v = v | ~((64'd1 << OW) - 64'd1);
    return v;
  endfunction

  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic frac_res_t rational_predict(logic [2:0] act, logic [31:0] an_i,
                                                 logic [31:0] ad_i, logic [31:0] bn_i,
                                                 logic [31:0] bd_i);
    logic [63:0] an, ad, bn, bd, p, q, x, y, r, g;
    frac_res_t o;
    an = sext_op(an_i); ad = sext_op(ad_i);
    bn = sext_op(bn_i); bd = sext_op(bd_i);
    o = '{num: 64'd0, den: 64'd0, status: ST_OK};
    case (act)
      ACT_ADD, ACT_SUB: begin
        p = an * bd;
        q = ad * bn;
        o.den = ad * bd;
        if (act == ACT_ADD) begin
          o.num = p + q;
          if (p[63] == q[63] && o.num[63] != p[63]) o.status = ST_OVERFLOW;
        end else begin
          o.num = p - q;
          if (p[63] != q[63] && o.num[63] != p[63]) o.status = ST_OVERFLOW;
        end
        if (o.status == ST_OK && o.den == 0) o.status = ST_DEN_ZERO;
      end
      ACT_MUL, ACT_DIV: begin
        o.num = (act == ACT_MUL) ? an * bn : an * bd;
        o.den = (act == ACT_MUL) ? ad * bd : ad * bn;
        if (o.den == 0) o.status = ST_DEN_ZERO;
      end
      ACT_SIMP: begin
        x = mag64(an); y = mag64(ad);
        while (y != 0) begin
          r = x % y; x = y; y = r;
        end
        g = x;
        if (g == 0) begin
          o.status = ST_ZERO_ZERO;
        end else begin
          o.num = an[63] ? -(mag64(an) / g) : mag64(an) / g;
          o.den = ad[63] ? -(mag64(ad) / g) : mag64(ad) / g;
          if (o.den == 0) o.status = ST_DEN_ZERO;
        end
      end
      default: o.status = ST_DEN_ZERO;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
      4, 5: return $urandom_range(0, 200) - 100;
      6: return ($urandom_range(0, 1000) - 500) * (1 << $urandom_range(0, 20));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, bit typed, frac_res_t res);
    frac_res_t pred;
    int gap;
    pred = rational_predict(act, an, ad, bn, bd);
    if (typed && pred != res) begin
      $error("table row disagrees with predictor: act %0d", act);
      errors++;
    end
    s_tdata <= {5'd0, bd, bn, ad, an, act};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(typed ? res : pred);
    @(negedge clk);
    if ($urandom_range(0, 2) == 0) begin
      s_tvalid <= 0;
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    logic [31:0] ops[4];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    table_rows = '{
      '{ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 1, '{64'd5, 64'd6, ST_OK}},
      '{ACT_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 1, '{64'd1, 64'd6, ST_OK}},
      '{ACT_MUL, 32'd2, 32'd3, 32'd5, 32'd7, 1, '{64'd10, 64'd21, ST_OK}},
      '{ACT_DIV, 32'd2, 32'd3, 32'd5, 32'd7, 1, '{64'd14, 64'd15, ST_OK}},
      '{ACT_SIMP, 32'd6, 32'd8, 32'd0, 32'd0, 1, '{64'd3, 64'd4, ST_OK}},
      '{ACT_SIMP, 32'd0, 32'd0, 32'd5, 32'd9, 1, '{64'd0, 64'd0, ST_ZERO_ZERO}},
      '{ACT_SIMP, 32'd7, 32'd0, 32'd0, 32'd0, 1, '{64'd1, 64'd0, ST_DEN_ZERO}},
      '{ACT_SIMP, -32'sd7, 32'd0, 32'd0, 32'd0, 1, '{-64'sd1, 64'd0, ST_DEN_ZERO}},
      '{ACT_SIMP, 32'd0, -32'sd5, 32'd0, 32'd0, 1, '{64'd0, -64'sd1, ST_OK}},
      '{ACT_MUL, 32'd3, 32'd0, 32'd4, 32'd5, 1, '{64'd12, 64'd0, ST_DEN_ZERO}},
      '{ACT_DIV, 32'd3, 32'd1, 32'd0, 32'd5, 1, '{64'd15, 64'd0, ST_DEN_ZERO}},
      '{3'd5, 32'd1, 32'd1, 32'd1, 32'd1, 1, '{64'd0, 64'd0, ST_DEN_ZERO}},
      '{3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1,
        '{64'd0, 64'd0, ST_DEN_ZERO}},
      '{3'd7, 32'd0, 32'd0, 32'd0, 32'd0, 1, '{64'd0, 64'd0, ST_DEN_ZERO}},
      '{ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0}},
      '{ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, '{0, 0, 0}},
      '{ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, '{0, 0, 0}},
      '{ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '{0, 0, 0}},
      '{ACT_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, '{0, 0, 0}},
      '{ACT_SIMP, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 0, '{0, 0, 0}},
      '{ACT_SIMP, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, 0, '{0, 0, 0}},
      '{ACT_SIMP, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd0, 0, '{0, 0, 0}},
      '{ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd0, 0, '{0, 0, 0}}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_beat(row.action, row.an, row.ad, row.bn, row.bd, row.typed, row.res);
    end
    for (int n = 0; n < 2000; n++) begin
      if (n == 400) hold_off_req = 1;
      if (n == 1000) begin
        s_tvalid <= 0;
        while (expected_results.size() != 0) @(negedge clk);
      end
      for (int k = 0; k < 4; k++) ops[k] = rand_operand();
      send_beat(($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4)),
                ops[0], ops[1], ops[2], ops[3], 0, '{0, 0, 0});
    end
    s_tvalid <= 0;
    stim_done = 1;
  end

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        m_tready <= 0;
        repeat (600) @(negedge clk);
      end
      m_tready <= 1;
      if ($urandom_range(0, 3) == 0) begin
        @(negedge clk);
        m_tready <= 0;
        gap = ($urandom_range(0, 20) == 0) ? $urandom_range(30, 300) : $urandom_range(1, 5);
        repeat (gap) @(negedge clk);
      end else begin
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{num: m_tdata[63:0], den: m_tdata[127:64], status: m_tdata[129:128]};
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.num !== want.num) begin
          $error("res_num: expected %h, actual %h", want.num, got.num);
          errors++;
        end
        if (got.den !== want.den) begin
          $error("res_den: expected %h, actual %h", want.den, got.den);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
